@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros shared by the rtl, removable with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("concurrent assertion failed");

// implication checked at every clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("concurrent implication failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/hsv2rgb_pkg.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// types, constants and helper functions of the hsv to rgb pipeline
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

    // field widths
    localparam int HUE_W  = 12;
    localparam int SAT_W  = 12;
    localparam int VAL_W  = 11;
    localparam int CHAN_W = 8;

    // internal widths
    localparam int S_W    = 11;  // clamped saturation, 0..1024
    localparam int E_W    = 10;  // position in sector, 0..600
    localparam int VS_W   = 18;  // 255 * v
    localparam int NUM_W  = 20;  // ramp numerator, 0..614400
    localparam int X_W    = 15;  // ramp product scaled by 2^-23
    localparam int RCP_W  = 16;  // reciprocal of 75

    localparam logic [HUE_W-1:0]  HUE_TURN   = 12'd3600;
    localparam logic [E_W-1:0]    HUE_SECTOR = 10'd600;
    localparam logic [S_W-1:0]    Q_ONE      = 11'd1024;
    localparam logic [NUM_W-1:0]  NUM_FULL   = 20'd614400;
    // floor(x / 75) == (x * RECIP_75) >> 22 for x < 2^15
    localparam logic [RCP_W-1:0]  RECIP_75   = 16'd55925;
    localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'd255;

    // sector code, named by the channel at maximum and the ramping channel
    typedef enum logic [2:0] {
        SECT_R_GUP = 3'd0,
        SECT_G_RDN = 3'd1,
        SECT_G_BUP = 3'd2,
        SECT_B_GDN = 3'd3,
        SECT_B_RUP = 3'd4,
        SECT_R_BDN = 3'd5
    } t_sector;

    // stage 2 payload: sector, position, saturation and value
    typedef struct packed {
        t_sector          sector;
        logic [E_W-1:0]   e;
        logic [S_W-1:0]   sat;
        logic [S_W-1:0]   val;
    } t_s2;

    // stage 4 payload: channel levels before the final divide
    typedef struct packed {
        t_sector           sector;
        logic [CHAN_W-1:0] hi;
        logic [CHAN_W-1:0] lo;
        logic [X_W-1:0]    x;
    } t_s4;

    // sector lookup over the wrapped hue
    function automatic t_sector sector_of(input logic [HUE_W-1:0] h);
        t_sector sec;
        if (h >= 12'd3000) begin
            sec = SECT_R_BDN;
        end else if (h >= 12'd2400) begin
            sec = SECT_B_RUP;
        end else if (h >= 12'd1800) begin
            sec = SECT_B_GDN;
        end else if (h >= 12'd1200) begin
            sec = SECT_G_BUP;
        end else if (h >= 12'd600) begin
            sec = SECT_G_RDN;
        end else begin
            sec = SECT_R_GUP;
        end
        return sec;
    endfunction

    // hue at the start of a sector
    function automatic logic [HUE_W-1:0] sector_base(input t_sector sec);
        logic [HUE_W-1:0] base;
        case (sec)
            SECT_R_GUP: base = 12'd0;
            SECT_G_RDN: base = 12'd600;
            SECT_G_BUP: base = 12'd1200;
            SECT_B_GDN: base = 12'd1800;
            SECT_B_RUP: base = 12'd2400;
            SECT_R_BDN: base = 12'd3000;
            default:    base = 12'd0;
        endcase
        return base;
    endfunction

    // sectors where the ramping channel falls with hue
    function automatic logic sector_falls(input t_sector sec);
        logic falls;
        case (sec)
            SECT_G_RDN: falls = 1'b1;
            SECT_B_GDN: falls = 1'b1;
            SECT_R_BDN: falls = 1'b1;
            default:    falls = 1'b0;
        endcase
        return falls;
    endfunction

endpackage

@@ rtl/hsv2rgb_prep.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_prep
// stages 1 and 2: hue wrap and clamps, then sector and position in sector
// ----------------------------------------------------------------------------
module hsv2rgb_prep (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic [hsv2rgb_pkg::HUE_W-1:0]      i_hue_tenths,
    input  logic signed [hsv2rgb_pkg::SAT_W-1:0] i_saturation,
    input  logic [hsv2rgb_pkg::VAL_W-1:0]      i_brightness,
    output logic                               o_valid,
    output hsv2rgb_pkg::t_s2                   o_data
);

    logic                            r_v1;
    logic [hsv2rgb_pkg::HUE_W-1:0]   r_hue, n_hue;
    logic [hsv2rgb_pkg::S_W-1:0]     r_sat1, n_sat1;
    logic [hsv2rgb_pkg::S_W-1:0]     r_val1, n_val1;
    logic                            r_v2;
    hsv2rgb_pkg::t_s2                r_s2, n_s2;
    logic [hsv2rgb_pkg::HUE_W-1:0]   f_full;

    // wrap hue once and clamp saturation and value
    always_comb begin
        if (i_hue_tenths >= hsv2rgb_pkg::HUE_TURN) begin
            n_hue = i_hue_tenths - hsv2rgb_pkg::HUE_TURN;
        end else begin
            n_hue = i_hue_tenths;
        end
        if (i_saturation[hsv2rgb_pkg::SAT_W-1]) begin
            n_sat1 = '0;
        end else if (i_saturation[hsv2rgb_pkg::S_W-1:0] > hsv2rgb_pkg::Q_ONE) begin
            n_sat1 = hsv2rgb_pkg::Q_ONE;
        end else begin
            n_sat1 = i_saturation[hsv2rgb_pkg::S_W-1:0];
        end
        if (i_brightness > hsv2rgb_pkg::Q_ONE) begin
            n_val1 = hsv2rgb_pkg::Q_ONE;
        end else begin
            n_val1 = i_brightness;
        end
    end

    // sector, offset in sector, mirrored for falling sectors
    always_comb begin
        n_s2.sector = hsv2rgb_pkg::sector_of(r_hue);
        f_full      = r_hue - hsv2rgb_pkg::sector_base(n_s2.sector);
        if (hsv2rgb_pkg::sector_falls(n_s2.sector)) begin
            n_s2.e = hsv2rgb_pkg::HUE_SECTOR - f_full[hsv2rgb_pkg::E_W-1:0];
        end else begin
            n_s2.e = f_full[hsv2rgb_pkg::E_W-1:0];
        end
        n_s2.sat = r_sat1;
        n_s2.val = r_val1;
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        r_hue  <= n_hue;
        r_sat1 <= n_sat1;
        r_val1 <= n_val1;
        r_s2   <= n_s2;
    end

    assign o_valid = r_v2;
    assign o_data  = r_s2;

endmodule

@@ rtl/hsv2rgb_mult.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_mult
// stages 3 and 4: scaled value and ramp numerator, then channel products
// ----------------------------------------------------------------------------
module hsv2rgb_mult (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  hsv2rgb_pkg::t_s2 i_data,
    output logic             o_valid,
    output hsv2rgb_pkg::t_s4 o_data
);

    localparam int T_W   = hsv2rgb_pkg::S_W + hsv2rgb_pkg::E_W;
    localparam int LO_W  = hsv2rgb_pkg::VS_W + hsv2rgb_pkg::S_W;
    localparam int MID_W = hsv2rgb_pkg::VS_W + hsv2rgb_pkg::NUM_W;

    logic                              r_v3;
    hsv2rgb_pkg::t_sector              r_sec3;
    logic [hsv2rgb_pkg::VS_W-1:0]      r_vs, n_vs;
    logic [hsv2rgb_pkg::NUM_W-1:0]     r_num, n_num;
    logic [hsv2rgb_pkg::S_W-1:0]       r_oms, n_oms;
    logic [hsv2rgb_pkg::VS_W:0]        vs_full;
    logic [hsv2rgb_pkg::E_W-1:0]       span;
    logic [T_W-1:0]                    t_prod;
    logic [LO_W-1:0]                   lo_prod;
    logic [MID_W-1:0]                  mid_prod;
    logic                              r_v4;
    hsv2rgb_pkg::t_s4                  r_s4, n_s4;

    // 255*v, saturation times distance to sector end, 1 - s
    always_comb begin
        vs_full = {i_data.val, 8'b0} - {8'b0, i_data.val};
        n_vs    = vs_full[hsv2rgb_pkg::VS_W-1:0];
        span    = hsv2rgb_pkg::HUE_SECTOR - i_data.e;
        t_prod  = {{hsv2rgb_pkg::E_W{1'b0}}, i_data.sat}
                * {{hsv2rgb_pkg::S_W{1'b0}}, span};
        n_num   = hsv2rgb_pkg::NUM_FULL - t_prod[hsv2rgb_pkg::NUM_W-1:0];
        n_oms   = hsv2rgb_pkg::Q_ONE - i_data.sat;
    end

    // max, min and scaled ramp product
    always_comb begin
        lo_prod     = {{hsv2rgb_pkg::S_W{1'b0}}, r_vs}
                    * {{hsv2rgb_pkg::VS_W{1'b0}}, r_oms};
        mid_prod    = {{hsv2rgb_pkg::NUM_W{1'b0}}, r_vs}
                    * {{hsv2rgb_pkg::VS_W{1'b0}}, r_num};
        n_s4.sector = r_sec3;
        n_s4.hi     = r_vs[hsv2rgb_pkg::VS_W-1:10];
        n_s4.lo     = lo_prod[27:20];
        n_s4.x      = mid_prod[MID_W-1:23];
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v3 <= i_valid;
            r_v4 <= r_v3;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        r_sec3 <= i_data.sector;
        r_vs   <= n_vs;
        r_num  <= n_num;
        r_oms  <= n_oms;
        r_s4   <= n_s4;
    end

    assign o_valid = r_v4;
    assign o_data  = r_s4;

endmodule

@@ rtl/hsv2rgb_out.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_out
// stage 5: ramp divide by 75 through a reciprocal, channel routing by sector
// ----------------------------------------------------------------------------
module hsv2rgb_out (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  hsv2rgb_pkg::t_s4                   i_data,
    output logic                               o_valid,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]     o_red,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]     o_green,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]     o_blue
);

    localparam int Y_W = hsv2rgb_pkg::X_W + hsv2rgb_pkg::RCP_W;

    logic [Y_W-1:0]                    y_prod;
    logic [hsv2rgb_pkg::CHAN_W-1:0]    mid;
    logic                              r_v5;
    logic [hsv2rgb_pkg::CHAN_W-1:0]    r_red, n_red;
    logic [hsv2rgb_pkg::CHAN_W-1:0]    r_green, n_green;
    logic [hsv2rgb_pkg::CHAN_W-1:0]    r_blue, n_blue;

    // ramp channel: floor(x / 75)
    always_comb begin
        y_prod = {{hsv2rgb_pkg::RCP_W{1'b0}}, i_data.x}
               * {{hsv2rgb_pkg::X_W{1'b0}}, hsv2rgb_pkg::RECIP_75};
        mid    = y_prod[29:22];
    end

    // route max, min and ramp to the channels
    always_comb begin
        case (i_data.sector)
            hsv2rgb_pkg::SECT_R_GUP: begin
                n_red = i_data.hi; n_green = mid;       n_blue = i_data.lo;
            end
            hsv2rgb_pkg::SECT_G_RDN: begin
                n_red = mid;       n_green = i_data.hi; n_blue = i_data.lo;
            end
            hsv2rgb_pkg::SECT_G_BUP: begin
                n_red = i_data.lo; n_green = i_data.hi; n_blue = mid;
            end
            hsv2rgb_pkg::SECT_B_GDN: begin
                n_red = i_data.lo; n_green = mid;       n_blue = i_data.hi;
            end
            hsv2rgb_pkg::SECT_B_RUP: begin
                n_red = mid;       n_green = i_data.lo; n_blue = i_data.hi;
            end
            default: begin
                n_red = i_data.hi; n_green = i_data.lo; n_blue = mid;
            end
        endcase
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else begin
            r_v5 <= i_valid;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        r_red   <= n_red;
        r_green <= n_green;
        r_blue  <= n_blue;
    end

    assign o_valid = r_v5;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

@@ rtl/hsv_to_rgb_converter_unit.sv @@
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_unit
// fixed-point hsv to 8-bit rgb conversion, one transaction per clock
// ----------------------------------------------------------------------------
// A transaction is taken at every clock edge where start is high; busy stays
// low, so one hue/saturation/value triple can enter in every cycle. Each
// result appears on o_red, o_green and o_blue with o_valid high for exactly
// one cycle, in input order, after it has passed the five register stages
// (clamp, sector, product set-up, channel products, divide and routing). The
// receiver cannot stall the pipeline and must take every result in the cycle
// it is shown. Hue beyond one turn wraps once, saturation is clamped to
// 0..1.0 and brightness to 1.0.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hsv_to_rgb_converter_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [hsv2rgb_pkg::HUE_W-1:0]         i_hue_tenths,
    input  logic signed [hsv2rgb_pkg::SAT_W-1:0]  i_saturation,
    input  logic [hsv2rgb_pkg::VAL_W-1:0]         i_brightness,
    output logic                                  o_valid,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]        o_red,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]        o_green,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]        o_blue
);

    logic             accept;
    logic             s2_valid;
    hsv2rgb_pkg::t_s2 s2_data;
    logic             s4_valid;
    hsv2rgb_pkg::t_s4 s4_data;

    // the pipeline never stalls
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // clamp and sector stages
    hsv2rgb_prep u_prep (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (accept),
        .i_hue_tenths (i_hue_tenths),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_valid      (s2_valid),
        .o_data       (s2_data)
    );

    // multiply stages
    hsv2rgb_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .i_data  (s2_data),
        .o_valid (s4_valid),
        .o_data  (s4_data)
    );

    // divide and routing stage
    hsv2rgb_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s4_valid),
        .i_data  (s4_data),
        .o_valid (o_valid),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue)
    );

    // every accepted transaction, and nothing else, comes out unless reset cuts in
    `ASSERT_ALWAYS(a_latency, i_clk, i_rst_n, o_valid == ($past(accept, 5) && $past(i_rst_n, 5) && $past(i_rst_n, 4) && $past(i_rst_n, 3) && $past(i_rst_n, 2) && $past(i_rst_n, 1)))

    // zero or negative saturation gives grey
    `ASSERT_IMPLY(a_grey, i_clk, i_rst_n, o_valid && $past(accept && (i_saturation <= 0), 5), (o_red == o_green) && (o_green == o_blue))

    // full saturation and brightness span the whole channel range
    `ASSERT_IMPLY(a_full_span, i_clk, i_rst_n, o_valid && $past(accept && (i_saturation >= 1024) && (i_brightness >= 1024), 5), ((o_red == hsv2rgb_pkg::CHAN_MAX) || (o_green == hsv2rgb_pkg::CHAN_MAX) || (o_blue == hsv2rgb_pkg::CHAN_MAX)) && ((o_red == 0) || (o_green == 0) || (o_blue == 0)))

endmodule

@@ test/hsv_to_rgb_converter_unit_tb.sv @@
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_unit_tb
// self-checking bench: directed corner transactions, then random ones at three
// sender idle rates and around a drain pause; every result is checked against an in-bench prediction
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // expected color of one transaction
    typedef struct packed {
        logic [hsv2rgb_pkg::CHAN_W-1:0] red;
        logic [hsv2rgb_pkg::CHAN_W-1:0] green;
        logic [hsv2rgb_pkg::CHAN_W-1:0] blue;
    } t_rgb;

    localparam int CLK_HALF       = 5;
    localparam int STALL_LIMIT    = 1000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int RANDOM_PER_RUN = 360;

    // fixed-point constants of the conversion
    localparam longint unsigned TENTHS_PER_TURN   = 3600;
    localparam longint unsigned TENTHS_PER_SECTOR = 600;
    localparam longint unsigned FULL_LEVEL        = 255;
    localparam longint unsigned UNITY_Q10         = 1024;

    logic                                  i_clk;
    logic                                  i_rst_n;
    logic                                  start;
    logic                                  busy;
    logic [hsv2rgb_pkg::HUE_W-1:0]         i_hue_tenths;
    logic signed [hsv2rgb_pkg::SAT_W-1:0]  i_saturation;
    logic [hsv2rgb_pkg::VAL_W-1:0]         i_brightness;
    logic                                  o_valid;
    logic [hsv2rgb_pkg::CHAN_W-1:0]        o_red;
    logic [hsv2rgb_pkg::CHAN_W-1:0]        o_green;
    logic [hsv2rgb_pkg::CHAN_W-1:0]        o_blue;

    t_rgb pending_rgb_q[$];
    int   error_count     = 0;
    int   sender_idle_pct = 0;
    int   quiet_cycles    = 0;

    hsv_to_rgb_converter_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_hue_tenths (i_hue_tenths),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_valid      (o_valid),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // color the block should produce for one hsv triple
    function automatic t_rgb predict_rgb(input logic [hsv2rgb_pkg::HUE_W-1:0] hue,
                                         input logic signed [hsv2rgb_pkg::SAT_W-1:0] sat,
                                         input logic [hsv2rgb_pkg::VAL_W-1:0] bri);
        longint unsigned      h, s, v, f, e, hi, lo, mid;
        hsv2rgb_pkg::t_sector sec;
        t_rgb                 rgb;
        h = hue;
        if (h >= TENTHS_PER_TURN) begin
            h = h - TENTHS_PER_TURN;
        end
        // saturation clamps to 0..1.0, brightness saturates at 1.0
        if (sat < 0) begin
            s = 0;
        end else if (sat > $signed(hsv2rgb_pkg::SAT_W'(UNITY_Q10))) begin
            s = UNITY_Q10;
        end else begin
            s = longint'(sat);
        end
        v = (bri > UNITY_Q10) ? UNITY_Q10 : longint'(bri);
        sec = hsv2rgb_pkg::t_sector'(h / TENTHS_PER_SECTOR);
        f   = h - (h / TENTHS_PER_SECTOR) * TENTHS_PER_SECTOR;
        // ramp falls in odd sectors
        e   = ((h / TENTHS_PER_SECTOR) % 2 == 1) ? TENTHS_PER_SECTOR - f : f;
        hi  = (FULL_LEVEL * v) / UNITY_Q10;
        lo  = (FULL_LEVEL * v * (UNITY_Q10 - s)) / (UNITY_Q10 * UNITY_Q10);
        mid = (FULL_LEVEL * v * (UNITY_Q10 * TENTHS_PER_SECTOR - s * (TENTHS_PER_SECTOR - e)))
              / (UNITY_Q10 * UNITY_Q10 * TENTHS_PER_SECTOR);
        case (sec)
            hsv2rgb_pkg::SECT_R_GUP: rgb = '{hsv2rgb_pkg::CHAN_W'(hi),
                                             hsv2rgb_pkg::CHAN_W'(mid),
                                             hsv2rgb_pkg::CHAN_W'(lo)};
            hsv2rgb_pkg::SECT_G_RDN: rgb = '{hsv2rgb_pkg::CHAN_W'(mid),
                                             hsv2rgb_pkg::CHAN_W'(hi),
                                             hsv2rgb_pkg::CHAN_W'(lo)};
            hsv2rgb_pkg::SECT_G_BUP: rgb = '{hsv2rgb_pkg::CHAN_W'(lo),
                                             hsv2rgb_pkg::CHAN_W'(hi),
                                             hsv2rgb_pkg::CHAN_W'(mid)};
            hsv2rgb_pkg::SECT_B_GDN: rgb = '{hsv2rgb_pkg::CHAN_W'(lo),
                                             hsv2rgb_pkg::CHAN_W'(mid),
                                             hsv2rgb_pkg::CHAN_W'(hi)};
            hsv2rgb_pkg::SECT_B_RUP: rgb = '{hsv2rgb_pkg::CHAN_W'(mid),
                                             hsv2rgb_pkg::CHAN_W'(lo),
                                             hsv2rgb_pkg::CHAN_W'(hi)};
            default:                 rgb = '{hsv2rgb_pkg::CHAN_W'(hi),
                                             hsv2rgb_pkg::CHAN_W'(lo),
                                             hsv2rgb_pkg::CHAN_W'(mid)};
        endcase
        return rgb;
    endfunction

    // send one transaction, with random idle cycles ahead of it
    task automatic send_hsv(input logic [hsv2rgb_pkg::HUE_W-1:0] hue,
                            input logic signed [hsv2rgb_pkg::SAT_W-1:0] sat,
                            input logic [hsv2rgb_pkg::VAL_W-1:0] bri);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start        = 1'b1;
        i_hue_tenths = hue;
        i_saturation = sat;
        i_brightness = bri;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        pending_rgb_q.push_back(predict_rgb(hue, sat, bri));
        @(negedge i_clk);
    endtask

    // mostly legal triples, some over the full field range
    task automatic send_random_hsv();
        logic [hsv2rgb_pkg::HUE_W-1:0]        hue;
        logic signed [hsv2rgb_pkg::SAT_W-1:0] sat;
        logic [hsv2rgb_pkg::VAL_W-1:0]        bri;
        if ($urandom_range(0, 9) < 8) begin
            hue = hsv2rgb_pkg::HUE_W'($urandom_range(0, 3599));
            sat = hsv2rgb_pkg::SAT_W'($urandom_range(0, 1024));
            bri = hsv2rgb_pkg::VAL_W'($urandom_range(0, 1024));
        end else begin
            hue = hsv2rgb_pkg::HUE_W'($urandom_range(0, 4095));
            sat = hsv2rgb_pkg::SAT_W'($urandom_range(0, 4095));
            bri = hsv2rgb_pkg::VAL_W'($urandom_range(0, 2047));
        end
        // land on sector edges now and then
        if ($urandom_range(0, 15) == 0) begin
            hue = hsv2rgb_pkg::HUE_W'(600 * $urandom_range(0, 6) + $urandom_range(0, 1) - 1);
        end
        send_hsv(hue, sat, bri);
    endtask

    // field extremes, every sector, wrap and clamp cases
    task automatic test_corners();
        sender_idle_pct = 0;
        send_hsv(12'd0,    12'sd1024, 11'd1024);
        send_hsv(12'd599,  12'sd1024, 11'd1024);
        send_hsv(12'd600,  12'sd1024, 11'd1024);
        send_hsv(12'd1199, 12'sd1024, 11'd1024);
        send_hsv(12'd1200, 12'sd1024, 11'd1024);
        send_hsv(12'd1800, 12'sd512,  11'd1024);
        send_hsv(12'd2400, 12'sd1024, 11'd700);
        send_hsv(12'd3000, 12'sd1024, 11'd1024);
        send_hsv(12'd3599, 12'sd1024, 11'd1024);
        // hue beyond one turn
        send_hsv(12'd3600, 12'sd1024, 11'd1024);
        send_hsv(12'd4095, 12'sd800,  11'd1024);
        // negative saturation gives grey
        send_hsv(12'd900,  12'sh800,  11'd1024);
        send_hsv(12'd2000, -12'sd1,   11'd513);
        // saturation above one, then zero and one lsb
        send_hsv(12'd300,  12'sd1025, 11'd1024);
        send_hsv(12'd2700, 12'sd2047, 11'd1024);
        send_hsv(12'd1500, 12'sd0,    11'd1024);
        send_hsv(12'd1500, 12'sd1,    11'd1);
        // brightness at zero and above one
        send_hsv(12'd450,  12'sd1024, 11'd0);
        send_hsv(12'd3300, 12'sd1024, 11'd1025);
        send_hsv(12'd1700, 12'sd700,  11'd2047);
        send_hsv(12'hAAA,  12'sh555,  11'h2AA);
        send_hsv(12'h555,  -12'sh556, 11'h555);
    endtask

    // random transactions at one sender idle rate
    task automatic test_random(input int idle_pct, input int count);
        sender_idle_pct = idle_pct;
        repeat (count) send_random_hsv();
    endtask

    // hold the sender until the pipeline has emptied, then resume
    task automatic test_drain_pause();
        sender_idle_pct = 0;
        repeat (15) send_random_hsv();
        start = 1'b0;
        while (pending_rgb_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (15) send_random_hsv();
    endtask

    // result checking
    always @(posedge i_clk) begin
        t_rgb exp_rgb;
        if (i_rst_n && o_valid) begin
            if (pending_rgb_q.size() == 0) begin
                $error("unexpected result: red %0d green %0d blue %0d",
                       o_red, o_green, o_blue);
                error_count++;
            end else begin
                exp_rgb = pending_rgb_q.pop_front();
                if (o_red !== exp_rgb.red) begin
                    $error("red mismatch: expected %0d, actual %0d", exp_rgb.red, o_red);
                    error_count++;
                end
                if (o_green !== exp_rgb.green) begin
                    $error("green mismatch: expected %0d, actual %0d",
                           exp_rgb.green, o_green);
                    error_count++;
                end
                if (o_blue !== exp_rgb.blue) begin
                    $error("blue mismatch: expected %0d, actual %0d", exp_rgb.blue, o_blue);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction in either direction
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // test sequence
    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_hue_tenths = '0;
        i_saturation = '0;
        i_brightness = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_corners();
        test_random(19, RANDOM_PER_RUN);
        test_drain_pause();
        test_random(57, RANDOM_PER_RUN);
        test_random(0, RANDOM_PER_RUN);

        // drain the pipeline
        start = 1'b0;
        while (pending_rgb_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/hsv2rgb_pkg.sv
rtl/hsv2rgb_prep.sv
rtl/hsv2rgb_mult.sv
rtl/hsv2rgb_out.sv
rtl/hsv_to_rgb_converter_unit.sv
test/hsv_to_rgb_converter_unit_tb.sv
